FILE: hw/rtl/fac_pkg.sv
package fac_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] verdict_t;

  typedef logic signed [31:0] q_t;     // Q16.16 value
  typedef logic signed [32:0] dif_t;   // difference of two Q16.16 values
  typedef logic signed [63:0] qprod_t; // Q16.16 * Q16.16
  typedef logic signed [65:0] psum_t;  // plane sum / 33x33 product
  typedef logic signed [66:0] proj_t;  // axis projection, Q32.32

  localparam cmd_t CMD_LOAD_PLANE  = 2'd0;
  localparam cmd_t CMD_LOAD_CORNER = 2'd1;
  localparam cmd_t CMD_TEST        = 2'd2;

  localparam mode_t MODE_BASIC = 2'd0;
  localparam mode_t MODE_BOTH  = 2'd1;

  localparam verdict_t VERDICT_SEPARATE   = 2'd0;
  localparam verdict_t VERDICT_INTERSECTS = 2'd1;
  localparam verdict_t VERDICT_CONTAINS   = 2'd2;

  localparam int NSLOT = 24;
  localparam int NCRN  = 8;
  localparam int NPLN  = 6;
  localparam int NEDG  = 6;
  localparam int NAX   = 2 * NEDG;

  // frustum edges used for the cross axes, endpoint A minus endpoint B
  localparam int EDGE_A [NEDG] = '{2, 0, 4, 5, 6, 7};
  localparam int EDGE_B [NEDG] = '{3, 3, 0, 1, 2, 3};

  function automatic dif_t sx33(input q_t x);
    return {x[31], x};
  endfunction

  function automatic psum_t sx66(input qprod_t x);
    return {{2{x[63]}}, x};
  endfunction

  function automatic proj_t sx67(input psum_t x);
    return {x[65], x};
  endfunction

endpackage

FILE: hw/rtl/frustum_aabb_cull_test.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | command, slot, load_value, box bounds, test_mode
// out_    | output    | out_valid/out_stall| verdict (one beat per test command)
//
// One item per cycle while out_stall is low. A test beat crosses every stage register to out_valid;
// the depth is set by the 33x33 projection products and the min/max trees after them.
// Load beats write the plane or corner store at acceptance and produce no result.
// rst_n clears the stage valid bits only; the stores are undefined until loaded.
// A stalled output holds; earlier stages keep filling bubbles and in_stall rises
// only when every stage holds a beat.
module frustum_aabb_cull_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fac_pkg::cmd_t      in_command,
  input  logic [4:0]         in_slot,
  input  fac_pkg::q_t        in_load_value,
  input  fac_pkg::q_t        in_box_min_x,
  input  fac_pkg::q_t        in_box_min_y,
  input  fac_pkg::q_t        in_box_max_x,
  input  fac_pkg::q_t        in_box_max_y,
  input  fac_pkg::mode_t     in_test_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output fac_pkg::verdict_t  out_verdict
);
  import fac_pkg::*;

  q_t plane_r  [NSLOT];
  q_t corner_r [NSLOT];

  logic [7:1] vld_r;
  logic [7:1] rdy;
  logic       ld_acc;
  logic       test_acc;

  // stage 1: raw values and differences
  q_t    c1_r [NCRN][3];
  dif_t  d1_r [NCRN][3];
  dif_t  m1_1_r [NAX];
  dif_t  m2_1_r [NAX];
  dif_t  bdx_lo1_r, bdx_hi1_r, bdy_lo1_r, bdy_hi1_r, bnz1_r;
  q_t    pa1_r [NPLN];
  q_t    pb1_r [NPLN];
  q_t    pd1_r [NPLN];
  q_t    mnx1_r, mny1_r, mxx1_r, mxy1_r;
  mode_t mode1_r;

  // stage 2: products, frustum bounds
  psum_t  pu2_r [NAX][NCRN];
  psum_t  pz2_r [NAX][NCRN];
  psum_t  bu_lo2_r [NAX];
  psum_t  bu_hi2_r [NAX];
  psum_t  bz2_r [NAX];
  qprod_t pal2_r [NPLN];
  qprod_t pah2_r [NPLN];
  qprod_t pbl2_r [NPLN];
  qprod_t pbh2_r [NPLN];
  q_t     pd2_r [NPLN];
  q_t     lo2_r [3];
  q_t     hi2_r [3];
  q_t     mnx2_r, mny2_r, mxx2_r, mxy2_r;
  mode_t  mode2_r;
  q_t     lo_nxt [3];
  q_t     hi_nxt [3];

  // stage 3: projections, plane signs, bounds check
  proj_t      fv3_r [NAX][NCRN];
  proj_t      bva3_r [NAX];
  proj_t      bvb3_r [NAX];
  logic [3:0] in3_r [NPLN];
  logic       bnd3_r;
  mode_t      mode3_r;
  psum_t      pd3_nxt [NPLN];
  psum_t      ps3_nxt [NPLN][4];

  // stages 4..6: min/max reduction
  proj_t    fmn4_r [NAX][4];
  proj_t    fmx4_r [NAX][4];
  proj_t    bmn4_r [NAX];
  proj_t    bmx4_r [NAX];
  verdict_t bas4_r;
  mode_t    mode4_r;
  verdict_t bas_nxt;

  proj_t    fmn5_r [NAX][2];
  proj_t    fmx5_r [NAX][2];
  proj_t    bmn5_r [NAX];
  proj_t    bmx5_r [NAX];
  verdict_t bas5_r;
  mode_t    mode5_r;

  proj_t    fmn6_r [NAX];
  proj_t    fmx6_r [NAX];
  proj_t    bmn6_r [NAX];
  proj_t    bmx6_r [NAX];
  verdict_t bas6_r;
  mode_t    mode6_r;

  verdict_t verdict7_r;
  mode_t    mode7_r;
  logic     sep_nxt;
  verdict_t verdict_nxt;

  function automatic proj_t pmin(input proj_t a, input proj_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic proj_t pmax(input proj_t a, input proj_t b);
    return (a < b) ? b : a;
  endfunction

  // ---------------------------------------------------------------- handshake
  always_comb begin
    rdy[7] = !vld_r[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];
  assign ld_acc   = in_valid && !in_stall &&
                    (in_command == CMD_LOAD_PLANE || in_command == CMD_LOAD_CORNER);
  assign test_acc = in_valid && !in_stall && (in_command == CMD_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= test_acc;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stores
  // out-of-range slots drop the beat
  always_ff @(posedge clk) begin
    if (ld_acc && in_slot < 5'(NSLOT)) begin
      if (in_command == CMD_LOAD_PLANE) begin
        plane_r[in_slot] <= in_load_value;
      end else begin
        corner_r[in_slot] <= in_load_value;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int c = 0; c < NCRN; c++) begin
        for (int a = 0; a < 3; a++) begin
          c1_r[c][a] <= corner_r[c*3+a];
          d1_r[c][a] <= sx33(corner_r[c*3+a]) - sx33(corner_r[a]);
        end
      end
      // axis X cross e = (0, -ez, ey), axis Y cross e = (ez, 0, -ex)
      for (int e = 0; e < NEDG; e++) begin
        m1_1_r[2*e]   <= sx33(corner_r[EDGE_B[e]*3+2]) - sx33(corner_r[EDGE_A[e]*3+2]);
        m2_1_r[2*e]   <= sx33(corner_r[EDGE_A[e]*3+1]) - sx33(corner_r[EDGE_B[e]*3+1]);
        m1_1_r[2*e+1] <= sx33(corner_r[EDGE_A[e]*3+2]) - sx33(corner_r[EDGE_B[e]*3+2]);
        m2_1_r[2*e+1] <= sx33(corner_r[EDGE_B[e]*3]) - sx33(corner_r[EDGE_A[e]*3]);
      end
      bdx_lo1_r <= sx33(in_box_min_x) - sx33(corner_r[0]);
      bdx_hi1_r <= sx33(in_box_max_x) - sx33(corner_r[0]);
      bdy_lo1_r <= sx33(in_box_min_y) - sx33(corner_r[1]);
      bdy_hi1_r <= sx33(in_box_max_y) - sx33(corner_r[1]);
      bnz1_r    <= -sx33(corner_r[2]);
      for (int p = 0; p < NPLN; p++) begin
        pa1_r[p] <= plane_r[p*4];
        pb1_r[p] <= plane_r[p*4+1];
        pd1_r[p] <= plane_r[p*4+3];
      end
      mnx1_r  <= in_box_min_x;
      mny1_r  <= in_box_min_y;
      mxx1_r  <= in_box_max_x;
      mxy1_r  <= in_box_max_y;
      mode1_r <= in_test_mode;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_nxt[a] = c1_r[0][a];
      hi_nxt[a] = c1_r[0][a];
      for (int c = 1; c < NCRN; c++) begin
        if (c1_r[c][a] < lo_nxt[a]) lo_nxt[a] = c1_r[c][a];
        if (c1_r[c][a] > hi_nxt[a]) hi_nxt[a] = c1_r[c][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int j = 0; j < NAX; j++) begin
        pu2_r[j][0] <= '0;
        pz2_r[j][0] <= '0;
        for (int c = 1; c < NCRN; c++) begin
          pu2_r[j][c] <= m1_1_r[j] * ((j % 2 == 1) ? d1_r[c][0] : d1_r[c][1]);
          pz2_r[j][c] <= m2_1_r[j] * d1_r[c][2];
        end
        bu_lo2_r[j] <= m1_1_r[j] * ((j % 2 == 1) ? bdx_lo1_r : bdy_lo1_r);
        bu_hi2_r[j] <= m1_1_r[j] * ((j % 2 == 1) ? bdx_hi1_r : bdy_hi1_r);
        bz2_r[j]    <= m2_1_r[j] * bnz1_r;
      end
      for (int p = 0; p < NPLN; p++) begin
        pal2_r[p] <= pa1_r[p] * mnx1_r;
        pah2_r[p] <= pa1_r[p] * mxx1_r;
        pbl2_r[p] <= pb1_r[p] * mny1_r;
        pbh2_r[p] <= pb1_r[p] * mxy1_r;
        pd2_r[p]  <= pd1_r[p];
      end
      lo2_r   <= lo_nxt;
      hi2_r   <= hi_nxt;
      mnx2_r  <= mnx1_r;
      mny2_r  <= mny1_r;
      mxx2_r  <= mxx1_r;
      mxy2_r  <= mxy1_r;
      mode2_r <= mode1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // box corners: (min,min) (max,min) (max,max) (min,max); d scaled to Q32.32
  always_comb begin
    for (int p = 0; p < NPLN; p++) begin
      pd3_nxt[p]    = psum_t'({{18{pd2_r[p][31]}}, pd2_r[p], 16'b0});
      ps3_nxt[p][0] = sx66(pal2_r[p]) + sx66(pbl2_r[p]) + pd3_nxt[p];
      ps3_nxt[p][1] = sx66(pah2_r[p]) + sx66(pbl2_r[p]) + pd3_nxt[p];
      ps3_nxt[p][2] = sx66(pah2_r[p]) + sx66(pbh2_r[p]) + pd3_nxt[p];
      ps3_nxt[p][3] = sx66(pal2_r[p]) + sx66(pbh2_r[p]) + pd3_nxt[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < NAX; j++) begin
        for (int c = 0; c < NCRN; c++) begin
          fv3_r[j][c] <= sx67(pu2_r[j][c]) + sx67(pz2_r[j][c]);
        end
        bva3_r[j] <= sx67(bu_lo2_r[j]) + sx67(bz2_r[j]);
        bvb3_r[j] <= sx67(bu_hi2_r[j]) + sx67(bz2_r[j]);
      end
      for (int p = 0; p < NPLN; p++) begin
        for (int k = 0; k < 4; k++) begin
          in3_r[p][k] <= !ps3_nxt[p][k][65];
        end
      end
      bnd3_r  <= !(lo2_r[0] > mxx2_r || mnx2_r > hi2_r[0] ||
                   lo2_r[1] > mxy2_r || mny2_r > hi2_r[1] ||
                   lo2_r[2] > 0 || hi2_r[2] < 0);
      mode3_r <= mode2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    logic full;
    logic any_out;
    full    = 1'b1;
    any_out = 1'b0;
    for (int p = 0; p < NPLN; p++) begin
      if (in3_r[p] == 4'b0000) any_out = 1'b1;
      if (in3_r[p] != 4'b1111) full = 1'b0;
    end
    if (!bnd3_r || any_out) begin
      bas_nxt = VERDICT_SEPARATE;
    end else if (full) begin
      bas_nxt = VERDICT_CONTAINS;
    end else begin
      bas_nxt = VERDICT_INTERSECTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int j = 0; j < NAX; j++) begin
        for (int i = 0; i < 4; i++) begin
          fmn4_r[j][i] <= pmin(fv3_r[j][2*i], fv3_r[j][2*i+1]);
          fmx4_r[j][i] <= pmax(fv3_r[j][2*i], fv3_r[j][2*i+1]);
        end
        bmn4_r[j] <= pmin(bva3_r[j], bvb3_r[j]);
        bmx4_r[j] <= pmax(bva3_r[j], bvb3_r[j]);
      end
      bas4_r  <= bas_nxt;
      mode4_r <= mode3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int j = 0; j < NAX; j++) begin
        for (int i = 0; i < 2; i++) begin
          fmn5_r[j][i] <= pmin(fmn4_r[j][2*i], fmn4_r[j][2*i+1]);
          fmx5_r[j][i] <= pmax(fmx4_r[j][2*i], fmx4_r[j][2*i+1]);
        end
        bmn5_r[j] <= bmn4_r[j];
        bmx5_r[j] <= bmx4_r[j];
      end
      bas5_r  <= bas4_r;
      mode5_r <= mode4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int j = 0; j < NAX; j++) begin
        fmn6_r[j] <= pmin(fmn5_r[j][0], fmn5_r[j][1]);
        fmx6_r[j] <= pmax(fmx5_r[j][0], fmx5_r[j][1]);
        bmn6_r[j] <= bmn5_r[j];
        bmx6_r[j] <= bmx5_r[j];
      end
      bas6_r  <= bas5_r;
      mode6_r <= mode5_r;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    sep_nxt = 1'b0;
    for (int j = 0; j < NAX; j++) begin
      if (fmx6_r[j] < bmn6_r[j] || bmx6_r[j] < fmn6_r[j]) sep_nxt = 1'b1;
    end
    case (mode6_r)
      MODE_BASIC: begin
        verdict_nxt = bas6_r;
      end
      MODE_BOTH: begin
        verdict_nxt = (bas6_r == VERDICT_SEPARATE || sep_nxt) ? VERDICT_SEPARATE
                                                              : VERDICT_INTERSECTS;
      end
      default: begin
        verdict_nxt = sep_nxt ? VERDICT_SEPARATE : VERDICT_INTERSECTS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      verdict7_r <= verdict_nxt;
      mode7_r    <= mode6_r;
    end
  end

  assign out_valid   = vld_r[7];
  assign out_verdict = verdict7_r;

  // ---------------------------------------------------------------- checks
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with a free stage");

  a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
    test_acc |=> vld_r[1])
    else $error("accepted test beat missing from stage 1");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !rdy[4]) |=> vld_r[4])
    else $error("stalled beat dropped in stage 4");

  a_contains_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode7_r != MODE_BASIC) |-> (out_verdict != VERDICT_CONTAINS))
    else $error("contains reported outside plane-only mode");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fac_pkg::*;

  localparam cmd_t  CMD_NONE       = 2'd3;
  localparam mode_t MODE_AXIS      = 2'd2;
  localparam mode_t MODE_AXIS_ALT  = 2'd3;
  localparam int    NO_VERDICT     = -1;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cmd_t       cmd;
    logic [4:0] slot;
    q_t         val;
    q_t         mnx, mny, mxx, mxy;
    mode_t      mode;
    int         want;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  cmd_t       in_command = CMD_NONE;
  logic [4:0] in_slot = '0;
  q_t         in_load_value = '0;
  q_t         in_box_min_x = '0;
  q_t         in_box_min_y = '0;
  q_t         in_box_max_x = '0;
  q_t         in_box_max_y = '0;
  mode_t      in_test_mode = MODE_BASIC;
  logic       out_valid;
  logic       out_stall = 1'b0;
  verdict_t   out_verdict;

  q_t         plane_mem [NSLOT];
  q_t         corner_mem [NSLOT];
  verdict_t   verdict_q [$];
  beat_t      dir_tab [$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         n_errors = 0;
  int         n_beats = 0;
  int         n_tests = 0;
  int         n_checked = 0;
  int         n_verdict [3] = '{0, 0, 0};

  frustum_aabb_cull_test i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_slot      (in_slot),
    .in_load_value(in_load_value),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_test_mode (in_test_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("frustum_aabb_cull_test: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint crn(int c, int ax);
    return longint'(corner_mem[(c * 3 + ax) % NSLOT]);
  endfunction

  function automatic longint pln(int p, int k);
    return longint'(plane_mem[(p * 4 + k) % NSLOT]);
  endfunction

  function automatic wide_t proj(longint px, longint py, longint pz,
                                 longint ax, longint ay, longint az);
    wide_t s;
    s = wide_t'(px - crn(0, 0)) * wide_t'(ax);
    s = s + wide_t'(py - crn(0, 1)) * wide_t'(ay);
    return s + wide_t'(pz - crn(0, 2)) * wide_t'(az);
  endfunction

  function automatic verdict_t plane_verdict(longint bx[4], longint by[4]);
    longint lo [3];
    longint hi [3];
    longint v;
    wide_t  s;
    int     hits;
    bit     full;
    full = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo[a] = crn(0, a);
      hi[a] = lo[a];
      for (int c = 1; c < NCRN; c++) begin
        v = crn(c, a);
        if (v < lo[a]) lo[a] = v;
        if (v > hi[a]) hi[a] = v;
      end
    end
    // corner bounds first: box corners 0 and 2 hold min and max
    if (lo[0] > bx[2] || bx[0] > hi[0]) return VERDICT_SEPARATE;
    if (lo[1] > by[2] || by[0] > hi[1]) return VERDICT_SEPARATE;
    if (lo[2] > 0 || hi[2] < 0) return VERDICT_SEPARATE;
    for (int p = 0; p < NPLN; p++) begin
      hits = 0;
      for (int k = 0; k < 4; k++) begin
        s = wide_t'(pln(p, 0)) * wide_t'(bx[k]) + wide_t'(pln(p, 1)) * wide_t'(by[k])
            + wide_t'(pln(p, 3)) * 65536;
        if (s >= 0) hits++;
      end
      if (hits == 0) return VERDICT_SEPARATE;
      if (hits != 4) full = 1'b0;
    end
    return full ? VERDICT_CONTAINS : VERDICT_INTERSECTS;
  endfunction

  function automatic verdict_t axis_verdict(longint bx[4], longint by[4]);
    longint ex, ey, ez, ax, ay, az;
    wide_t  fmin, fmax, bmin, bmax, v;
    for (int e = 0; e < NEDG; e++) begin
      ex = crn(EDGE_A[e], 0) - crn(EDGE_B[e], 0);
      ey = crn(EDGE_A[e], 1) - crn(EDGE_B[e], 1);
      ez = crn(EDGE_A[e], 2) - crn(EDGE_B[e], 2);
      for (int n = 0; n < 2; n++) begin
        ax = n ? ez : 0;
        ay = n ? 0 : -ez;
        az = n ? -ex : ey;
        fmin = proj(crn(0, 0), crn(0, 1), crn(0, 2), ax, ay, az);
        fmax = fmin;
        for (int c = 1; c < NCRN; c++) begin
          v = proj(crn(c, 0), crn(c, 1), crn(c, 2), ax, ay, az);
          if (v < fmin) fmin = v;
          if (v > fmax) fmax = v;
        end
        bmin = proj(bx[0], by[0], 0, ax, ay, az);
        bmax = bmin;
        for (int k = 1; k < 4; k++) begin
          v = proj(bx[k], by[k], 0, ax, ay, az);
          if (v < bmin) bmin = v;
          if (v > bmax) bmax = v;
        end
        if (fmax < bmin || bmax < fmin) return VERDICT_SEPARATE;
      end
    end
    return VERDICT_INTERSECTS;
  endfunction

  // apply one accepted beat to the stores; return the verdict or NO_VERDICT
  function automatic int cull_predict(beat_t b);
    longint bx [4];
    longint by [4];
    verdict_t v;
    if (b.cmd == CMD_LOAD_PLANE || b.cmd == CMD_LOAD_CORNER) begin
      if (b.slot < NSLOT) begin
        if (b.cmd == CMD_LOAD_PLANE) plane_mem[b.slot] = b.val;
        else corner_mem[b.slot] = b.val;
      end
      return NO_VERDICT;
    end
    if (b.cmd != CMD_TEST) return NO_VERDICT;
    bx = '{longint'(b.mnx), longint'(b.mxx), longint'(b.mxx), longint'(b.mnx)};
    by = '{longint'(b.mny), longint'(b.mny), longint'(b.mxy), longint'(b.mxy)};
    if (b.mode == MODE_BASIC) return plane_verdict(bx, by);
    v = VERDICT_INTERSECTS;
    if (b.mode == MODE_BOTH && plane_verdict(bx, by) == VERDICT_SEPARATE)
      v = VERDICT_SEPARATE;
    if (v != VERDICT_SEPARATE) v = axis_verdict(bx, by);
    return v;
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, actual %0d", $time, out_verdict);
        n_errors++;
      end else begin
        if (out_verdict !== verdict_q[0]) begin
          $display("%0t: verdict expected %0d actual %0d", $time, verdict_q[0],
                   out_verdict);
          n_errors++;
        end
        if (verdict_q[0] <= VERDICT_CONTAINS) n_verdict[verdict_q[0]]++;
        n_checked++;
        void'(verdict_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_beat(beat_t b);
    int pv;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= b.cmd;
    in_slot       <= b.slot;
    in_load_value <= b.val;
    in_box_min_x  <= b.mnx;
    in_box_min_y  <= b.mny;
    in_box_max_x  <= b.mxx;
    in_box_max_y  <= b.mxy;
    in_test_mode  <= b.mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pv = cull_predict(b);
    if (pv != NO_VERDICT) begin
      n_tests++;
      // a typed-in verdict takes precedence over the predictor
      verdict_q.push_back((b.want != NO_VERDICT) ? verdict_t'(b.want) : verdict_t'(pv));
    end
    n_beats++;
  endtask

  function automatic beat_t load_beat(cmd_t c, int slot, q_t v);
    beat_t b;
    b = '{cmd: c, slot: slot[4:0], val: v, mnx: $urandom, mny: $urandom,
          mxx: $urandom, mxy: $urandom, mode: mode_t'($urandom_range(3)),
          want: NO_VERDICT};
    return b;
  endfunction

  function automatic beat_t test_beat(q_t mnx, q_t mny, q_t mxx, q_t mxy, mode_t m,
                                      int want);
    beat_t b;
    b = '{cmd: CMD_TEST, slot: 5'($urandom_range(31)), val: $urandom, mnx: mnx,
          mny: mny, mxx: mxx, mxy: mxy, mode: m, want: want};
    return b;
  endfunction

  function automatic q_t fx(int v);
    return q_t'(v <<< 16);
  endfunction

  // Q16.16 in [-r, r + 1) with a random fraction
  function automatic q_t rnd_q(int r);
    return q_t'(($urandom_range(2 * r) - r) <<< 16) + q_t'($urandom_range(16'hffff));
  endfunction

  // axis-aligned frustum from -hw..hw, -hh..hh, z from -zn to zf, with matching planes
  task automatic load_box_frustum(int hw, int hh, int zn, int zf);
    int xs [4] = '{-1, 1, 1, -1};
    int ys [4] = '{1, 1, -1, -1};
    int pv [NSLOT];
    pv = '{1, 0, 0, hw, -1, 0, 0, hw, 0, 1, 0, hh, 0, -1, 0, hh,
           0, 0, 1, zn, 0, 0, -1, zf};
    for (int s = 0; s < NSLOT; s++) send_beat(load_beat(CMD_LOAD_PLANE, s, fx(pv[s])));
    for (int c = 0; c < NCRN; c++) begin
      send_beat(load_beat(CMD_LOAD_CORNER, c * 3, fx(xs[c % 4] * hw)));
      send_beat(load_beat(CMD_LOAD_CORNER, c * 3 + 1, fx(ys[c % 4] * hh)));
      send_beat(load_beat(CMD_LOAD_CORNER, c * 3 + 2, fx(c < 4 ? -zn : zf)));
    end
  endtask

  // perspective-like frustum, planes random; full-range values now and then
  task automatic load_rnd_frustum();
    bit wild;
    int nw, fw, zn, zf;
    q_t v;
    wild = ($urandom_range(7) == 0);
    nw = $urandom_range(1, 12);
    fw = nw + $urandom_range(0, 30);
    zn = $urandom_range(0, 10);
    zf = $urandom_range(0, 30);
    for (int s = 0; s < NSLOT; s++) begin
      v = wild ? q_t'($urandom) : rnd_q((s % 4 == 3) ? 40 : 2);
      send_beat(load_beat(CMD_LOAD_PLANE, s, v));
    end
    for (int s = 0; s < NSLOT; s++) begin
      if (wild) v = q_t'($urandom);
      else if (s % 3 == 2) v = (s < 12) ? fx(-zn) + rnd_q(1) : fx(zf) + rnd_q(1);
      else v = (s < 12) ? rnd_q(nw) : rnd_q(fw);
      send_beat(load_beat(CMD_LOAD_CORNER, s, v));
    end
  endtask

  task automatic rnd_test();
    q_t x0, y0, x1, y1;
    int sel;
    sel = $urandom_range(19);
    if (sel < 2) begin
      x0 = $urandom; y0 = $urandom; x1 = $urandom; y1 = $urandom;
    end else begin
      x0 = rnd_q(40);
      y0 = rnd_q(40);
      x1 = x0 + rnd_q(20);
      y1 = y0 + rnd_q(20);
      if (sel > 4) begin
        // keep most boxes well-formed
        if (x1 < x0) x1 = x0 - x1 + x0;
        if (y1 < y0) y1 = y0 - y1 + y0;
      end
    end
    send_beat(test_beat(x0, y0, x1, y1, mode_t'($urandom_range(3)), NO_VERDICT));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pct_in [4]  = '{0, 54, 0, 37};
    int pct_out [4] = '{0, 0, 54, 37};
    int limit;
    int sel;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // known box frustum: x,y in [-10,10], z in [-5,5]
    load_box_frustum(10, 10, 5, 5);
    dir_tab.push_back(test_beat(fx(-1), fx(-1), fx(1), fx(1), MODE_BASIC,
                                VERDICT_CONTAINS));
    dir_tab.push_back(test_beat(fx(20), fx(20), fx(30), fx(30), MODE_BASIC,
                                VERDICT_SEPARATE));
    dir_tab.push_back(test_beat(fx(5), fx(-1), fx(15), fx(1), MODE_BASIC,
                                VERDICT_INTERSECTS));
    dir_tab.push_back(test_beat(fx(-1), fx(-1), fx(1), fx(1), MODE_BOTH,
                                VERDICT_INTERSECTS));
    dir_tab.push_back(test_beat(fx(20), fx(-1), fx(30), fx(1), MODE_AXIS,
                                VERDICT_SEPARATE));
    dir_tab.push_back(test_beat(fx(20), fx(-1), fx(30), fx(1), MODE_AXIS_ALT,
                                VERDICT_SEPARATE));
    dir_tab.push_back(test_beat(fx(-1), fx(-1), fx(1), fx(1), MODE_AXIS,
                                VERDICT_INTERSECTS));
    dir_tab.push_back(test_beat(fx(20), fx(20), fx(30), fx(30), MODE_BOTH,
                                VERDICT_SEPARATE));
    // extremes of the box fields, inverted box
    dir_tab.push_back(test_beat(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                32'sh7fffffff, MODE_BASIC, NO_VERDICT));
    dir_tab.push_back(test_beat(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                32'sh7fffffff, MODE_BOTH, NO_VERDICT));
    dir_tab.push_back(test_beat(fx(3), fx(3), fx(-3), fx(-3), MODE_BASIC, NO_VERDICT));
    dir_tab.push_back(test_beat(fx(3), fx(3), fx(-3), fx(-3), MODE_AXIS, NO_VERDICT));
    // ignored slots and the unused command
    dir_tab.push_back(load_beat(CMD_LOAD_PLANE, 24, 32'sh7fffffff));
    dir_tab.push_back(load_beat(CMD_LOAD_CORNER, 31, 32'sh80000000));
    dir_tab.push_back(load_beat(CMD_NONE, 0, 32'sh80000000));
    dir_tab.push_back(test_beat(fx(-1), fx(-1), fx(1), fx(1), MODE_BASIC,
                                VERDICT_CONTAINS));
    // extreme coefficient and coordinate values
    dir_tab.push_back(load_beat(CMD_LOAD_PLANE, 3, 32'sh7fffffff));
    dir_tab.push_back(load_beat(CMD_LOAD_PLANE, 0, 32'sh80000000));
    dir_tab.push_back(load_beat(CMD_LOAD_CORNER, 23, 32'sh7fffffff));
    dir_tab.push_back(load_beat(CMD_LOAD_CORNER, 0, 32'sh80000000));
    dir_tab.push_back(test_beat(32'sh80000000, fx(0), fx(0), fx(1), MODE_BASIC,
                                NO_VERDICT));
    dir_tab.push_back(test_beat(32'sh80000000, fx(0), 32'sh7fffffff, fx(1), MODE_BOTH,
                                NO_VERDICT));
    dir_tab.push_back(test_beat(fx(-1), fx(-1), fx(1), fx(1), MODE_AXIS, NO_VERDICT));
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_in[ph];
      recv_stall_pct = pct_out[ph];
      limit = n_beats + 150;
      load_rnd_frustum();
      while (n_beats < limit) begin
        sel = $urandom_range(99);
        if (sel < 3) load_rnd_frustum();
        else if (sel < 8) send_beat(load_beat(cmd_t'($urandom_range(1)),
                                              $urandom_range(31), $urandom));
        else if (sel < 10) send_beat(load_beat(CMD_NONE, $urandom_range(31), $urandom));
        else rnd_test();
      end
      // hold off until the pipeline has emptied
      wait_drained();
    end

    limit = 0;
    while (verdict_q.size() != 0 && limit < 10000) begin
      @(posedge clk);
      limit++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d beats, %0d box tests under four idle/stall mixes", n_beats,
             n_tests);
    $display("verdicts checked: %0d separate, %0d intersects, %0d contains",
             n_verdict[0], n_verdict[1], n_verdict[2]);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("frustum_aabb_cull_test: match");
    end else begin
      $display("%0d errors, %0d verdicts outstanding", n_errors, verdict_q.size());
      $display("frustum_aabb_cull_test: mismatch");
    end
    $finish;
  end

endmodule
